// ----- src/dsrhm_pkg.sv -----
`timescale 1ns / 1ps
// Package for the dual-stream rolling hash matcher: beat types, register map
// and multiplier step constants. No dependencies.
package dsrhm_pkg;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic       last_pair;
  } in_beat_t;

  typedef struct packed {
    logic        match_first;
    logic        match_second;
    logic [31:0] common_count;
    logic        final_result;
  } out_beat_t;

  typedef enum logic {
    REG_PATTERN_HASH   = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } reg_idx_e;

  localparam int unsigned HASH_W    = 64;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned CHUNK_W   = 16;
  localparam int unsigned CHUNK_SH  = 4;
  localparam int unsigned MUL_STEPS = HASH_W / CHUNK_W;
  localparam int unsigned STEP_W    = $clog2(MUL_STEPS);

endpackage

// ----- src/dual_stream_rolling_hash_match.sv -----
`timescale 1ns / 1ps
// A result passes through the input stage registers and then the output register.
// Throughput: one pair per cycle while no target rebuild runs and the output is not stalled.
// After a pattern_hash write the input is held off while a
// 64x16 multiplier rebuilds the window target (four partial products).
// Reset (rst_ni low, asynchronous) clears the control, configuration and stream state; registers return to
// pattern_hash 0 and pattern_length 1. History needs no clearing pass.
module dual_stream_rolling_hash_match #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dsrhm_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dsrhm_pkg::out_beat_t out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned PW = $clog2(MAX_PATTERN + 128) + 1;
  localparam int unsigned HW = dsrhm_pkg::HASH_W;
  localparam int unsigned CW = dsrhm_pkg::COUNT_W;
  localparam int unsigned LW = dsrhm_pkg::LEN_W;
  localparam int unsigned SW = dsrhm_pkg::STEP_W;
  localparam logic [CW-1:0] COUNT_MAX = '1;

  function automatic logic [HW-1:0] times_base(input logic [HW-1:0] x);
    times_base = (x << 5) - (x << 2) + x;
  endfunction

  // configuration
  logic [HW-1:0] pattern_hash_q;
  logic [LW-1:0] pattern_length_q;
  logic          cfg_wr;
  logic          hash_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign hash_wr = cfg_wr && (paddr[3] == dsrhm_pkg::REG_PATTERN_HASH);

  always_comb begin
    case (dsrhm_pkg::reg_idx_e'(paddr[3]))
      dsrhm_pkg::REG_PATTERN_HASH:   prdata = pattern_hash_q;
      dsrhm_pkg::REG_PATTERN_LENGTH: prdata = {{(64-LW){1'b0}}, pattern_length_q};
      default:                       prdata = '0;
    endcase
  end

  // stream state
  logic [HW-1:0] prefix1_q, prefix2_q, pos_power_q, start_power_q, target_q;
  logic [CW-1:0] pos_count_q, pair_count_q;
  logic [AW-1:0] wp_q;

  // target rebuild multiplier
  logic          mul_busy_q;
  logic [SW-1:0] mul_cnt_q;
  logic [HW-1:0] mul_acc_q, mul_acc_d;
  logic [HW-1:0] mul_prod;
  logic [dsrhm_pkg::CHUNK_W-1:0] mul_chunk;
  logic          mul_done;

  assign mul_chunk = start_power_q[{mul_cnt_q, {dsrhm_pkg::CHUNK_SH{1'b0}}} +: dsrhm_pkg::CHUNK_W];
  assign mul_prod  = pattern_hash_q * HW'(mul_chunk);
  assign mul_acc_d = mul_acc_q + (mul_prod << {mul_cnt_q, {dsrhm_pkg::CHUNK_SH{1'b0}}});
  assign mul_done  = mul_busy_q && (mul_cnt_q == SW'(dsrhm_pkg::MUL_STEPS - 1));

  // pipeline control
  logic s1_valid_q, out_valid_q;
  logic in_fire, s1_move;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !mul_busy_q && (!s1_valid_q || s1_move);
  assign in_fire    = in_valid_i && in_ready_o;

  // input stage
  logic [LW-1:0] len;
  logic          len_ok, win_full, win_eval;
  logic [HW-1:0] new1, new2;
  logic [PW-1:0] ra_wide;
  logic [AW-1:0] ra;
  logic [AW-1:0] wp_next;

  assign len      = (pattern_length_q == '0) ? LW'(1) : pattern_length_q;
  assign len_ok   = PW'(len) <= PW'(MAX_PATTERN);
  assign win_eval = len_ok && (({1'b0, pos_count_q} + (CW+1)'(1)) >= (CW+1)'(len));
  assign win_full = ({1'b0, pos_count_q} + (CW+1)'(1)) != (CW+1)'(len);
  assign new1     = prefix1_q + pos_power_q * HW'(in_data_i.byte_first);
  assign new2     = prefix2_q + pos_power_q * HW'(in_data_i.byte_second);
  assign wp_next  = (wp_q == AW'(MAX_PATTERN - 1)) ? '0 : wp_q + AW'(1);

  always_comb begin
    ra_wide = PW'(wp_q) + PW'(MAX_PATTERN) - PW'(len);
    if (ra_wide >= PW'(MAX_PATTERN)) begin
      ra_wide = ra_wide - PW'(MAX_PATTERN);
    end
    ra = len_ok ? ra_wide[AW-1:0] : '0;
  end

  // history: prefix values by position, both strings side by side
  logic [2*HW-1:0] hist_mem [MAX_PATTERN];
  logic [2*HW-1:0] hist_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hist_rd_q      <= hist_mem[ra];
      hist_mem[wp_q] <= {new2, new1};
    end
  end

  logic [HW-1:0] s1_new1_q, s1_new2_q, s1_target_q;
  logic          s1_eval_q, s1_full_q, s1_last_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_new1_q   <= new1;
      s1_new2_q   <= new2;
      s1_target_q <= target_q;
      s1_eval_q   <= win_eval;
      s1_full_q   <= win_full;
      s1_last_q   <= in_data_i.last_pair;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_hash_q   <= '0;
      pattern_length_q <= LW'(1);
    end else if (cfg_wr) begin
      if (paddr[3] == dsrhm_pkg::REG_PATTERN_HASH) begin
        pattern_hash_q <= pwdata;
      end else begin
        pattern_length_q <= pwdata[LW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      mul_cnt_q  <= '0;
    end else if (hash_wr) begin
      mul_busy_q <= 1'b1;
      mul_cnt_q  <= '0;
    end else if (mul_busy_q) begin
      mul_cnt_q <= mul_cnt_q + SW'(1);
      if (mul_done) begin
        mul_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hash_wr) begin
      mul_acc_q <= '0;
    end else if (mul_busy_q) begin
      mul_acc_q <= mul_acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix1_q     <= '0;
      prefix2_q     <= '0;
      pos_power_q   <= HW'(1);
      start_power_q <= HW'(1);
      target_q      <= '0;
      pos_count_q   <= '0;
      wp_q          <= '0;
    end else if (mul_done) begin
      target_q <= mul_acc_d;
    end else if (in_fire) begin
      if (in_data_i.last_pair) begin
        prefix1_q     <= '0;
        prefix2_q     <= '0;
        pos_power_q   <= HW'(1);
        start_power_q <= HW'(1);
        target_q      <= pattern_hash_q;
        pos_count_q   <= '0;
        wp_q          <= '0;
      end else begin
        prefix1_q   <= new1;
        prefix2_q   <= new2;
        pos_power_q <= times_base(pos_power_q);
        if (win_eval) begin
          start_power_q <= times_base(start_power_q);
          target_q      <= times_base(target_q);
        end
        if (pos_count_q != COUNT_MAX) begin
          pos_count_q <= pos_count_q + CW'(1);
        end
        wp_q <= wp_next;
      end
    end
  end

  // compare stage
  logic [HW-1:0] sub1, sub2;
  logic          m1, m2;
  logic [CW-1:0] pair_count_d;

  assign sub1 = s1_new1_q - (s1_full_q ? hist_rd_q[HW-1:0] : '0);
  assign sub2 = s1_new2_q - (s1_full_q ? hist_rd_q[2*HW-1:HW] : '0);
  assign m1   = s1_eval_q && (sub1 == s1_target_q);
  assign m2   = s1_eval_q && (sub2 == s1_target_q);
  assign pair_count_d = (m1 && m2 && (pair_count_q != COUNT_MAX)) ?
                        pair_count_q + CW'(1) : pair_count_q;

  dsrhm_pkg::out_beat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pair_count_q <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q  <= 1'b1;
        pair_count_q <= s1_last_q ? '0 : pair_count_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.match_first  <= m1;
      out_q.match_second <= m2;
      out_q.common_count <= pair_count_d;
      out_q.final_result <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // rebuilt target must equal hash times the current window start power
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(mul_busy_q) |-> (target_q == pattern_hash_q * start_power_q))
    else $error("target rebuild mismatch");

  // last pair returns the stream state to its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last_pair) |=>
      (prefix1_q == '0 && prefix2_q == '0 && pos_count_q == '0 && wp_q == '0))
    else $error("stream state not cleared after last pair");

  // common count only falls across a stream boundary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && !s1_last_q) |=> (pair_count_q >= $past(pair_count_q)))
    else $error("common count went backwards");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench for dual_stream_rolling_hash_match: streams of byte pairs with planted
// patterns, checked against an in-bench rolling hash predictor. Uses dsrhm_pkg.
module tb;

  localparam logic [63:0] HASH_BASE = 64'd29;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 60;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  dsrhm_pkg::in_beat_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  dsrhm_pkg::out_beat_t out_data_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [3:0]           paddr = '0;
  logic [63:0]          pwdata = '0;
  logic [63:0]          prdata;
  logic                 pready;

  dual_stream_rolling_hash_match DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register copies
  logic [63:0] cfg_hash = '0;
  logic [6:0]  cfg_len = 7'd1;

  // predictor state
  logic [63:0] pre_a, pre_b, pow_pos, pow_start;
  logic [63:0] hist_a [64];
  logic [63:0] hist_b [64];
  int unsigned seen, both_hits;

  dsrhm_pkg::in_beat_t  pending_pairs[$];
  dsrhm_pkg::out_beat_t expected_results[$];
  logic [7:0]           pat[$];

  logic        in_taken = 1'b0;
  bit          idle_on = 1'b1;
  bit          calm = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned common_hits = 0;
  int unsigned single_hits = 0;
  int unsigned phases = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_hash_state();
    pre_a = '0;
    pre_b = '0;
    pow_pos = 64'd1;
    pow_start = 64'd1;
    for (int k = 0; k < 64; k++) begin
      hist_a[k] = '0;
      hist_b[k] = '0;
    end
    seen = 0;
    both_hits = 0;
  endfunction

  function automatic dsrhm_pkg::out_beat_t advance_hashes(dsrhm_pkg::in_beat_t pair);
    logic [63:0] win, nxt_a, nxt_b, span_a, span_b, goal;
    dsrhm_pkg::out_beat_t res;
    win = (cfg_len == 7'd0) ? 64'd1 : {57'd0, cfg_len};
    nxt_a = pre_a + {56'd0, pair.byte_first} * pow_pos;
    nxt_b = pre_b + {56'd0, pair.byte_second} * pow_pos;
    res = '0;
    if (win <= 64 && {32'd0, seen} + 64'd1 >= win) begin
      goal = cfg_hash * pow_start;
      span_a = nxt_a;
      span_b = nxt_b;
      if ({32'd0, seen} + 64'd1 != win) begin
        span_a = span_a - hist_a[win - 1];
        span_b = span_b - hist_b[win - 1];
      end
      res.match_first = (span_a == goal);
      res.match_second = (span_b == goal);
      pow_start = pow_start * HASH_BASE;
      if (res.match_first && res.match_second && both_hits != 32'hFFFF_FFFF) begin
        both_hits++;
      end
    end
    for (int k = 63; k > 0; k--) begin
      hist_a[k] = hist_a[k - 1];
      hist_b[k] = hist_b[k - 1];
    end
    hist_a[0] = nxt_a;
    hist_b[0] = nxt_b;
    pre_a = nxt_a;
    pre_b = nxt_b;
    pow_pos = pow_pos * HASH_BASE;
    if (seen != 32'hFFFF_FFFF) begin
      seen++;
    end
    res.common_count = both_hits;
    res.final_result = pair.last_pair;
    if (pair.last_pair) begin
      clear_hash_state();
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // input and output monitor
  always @(posedge clk_i) begin
    dsrhm_pkg::out_beat_t want;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_results.push_back(advance_hashes(in_data_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, out_data_o);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.match_first && want.match_second) common_hits++;
        if (want.match_first ^ want.match_second) single_hits++;
        check_field("match_first", want.match_first, out_data_o.match_first);
        check_field("match_second", want.match_second, out_data_o.match_second);
        check_field("common_count", want.common_count, out_data_o.common_count);
        check_field("final_result", want.final_result, out_data_o.final_result);
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_pairs.pop_front();
        if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 7);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served++;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input dsrhm_pkg::reg_idx_e idx, input logic [63:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == dsrhm_pkg::REG_PATTERN_HASH) cfg_hash = value;
    else cfg_len = value[6:0];
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_pairs.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_pair(input logic [7:0] b1, input logic [7:0] b2, input bit last);
    dsrhm_pkg::in_beat_t pair;
    pair.byte_first = b1;
    pair.byte_second = b2;
    pair.last_pair = last;
    pending_pairs.push_back(pair);
    items_sent++;
  endtask

  // new pattern of the given window length, its hash written to the block
  task automatic load_pattern(input logic [6:0] len);
    int n;
    bit wide;
    logic [63:0] h, p;
    n = (len == 0) ? 1 : ((len > 64) ? 64 : len);
    wide = ($urandom_range(0, 3) == 0);
    pat.delete();
    h = '0;
    p = 64'd1;
    for (int k = 0; k < n; k++) begin
      pat.push_back(wide ? 8'($urandom_range(0, 255)) : 8'(8'h61 + $urandom_range(0, 2)));
      h = h + {56'd0, pat[k]} * p;
      p = p * HASH_BASE;
    end
    if ($urandom_range(0, 1)) begin
      write_reg(dsrhm_pkg::REG_PATTERN_HASH, h);
      write_reg(dsrhm_pkg::REG_PATTERN_LENGTH, {57'd0, len});
    end else begin
      write_reg(dsrhm_pkg::REG_PATTERN_LENGTH, {57'd0, len});
      write_reg(dsrhm_pkg::REG_PATTERN_HASH, h);
    end
  endtask

  task automatic queue_text(input int n, input bit with_last);
    logic [7:0] ta[$], tb2[$];
    int pos, plen, which;
    bit noisy;
    noisy = ($urandom_range(0, 3) == 0);
    plen = pat.size();
    for (int k = 0; k < n; k++) begin
      ta.push_back(noisy ? 8'($urandom_range(0, 255)) : 8'(8'h61 + $urandom_range(0, 2)));
      tb2.push_back(noisy ? 8'($urandom_range(0, 255)) : 8'(8'h61 + $urandom_range(0, 2)));
    end
    pos = 0;
    while (pos + plen <= n) begin
      if ($urandom_range(0, 2) == 0) begin
        which = $urandom_range(0, 3);
        for (int k = 0; k < plen; k++) begin
          if (which != 1) ta[pos + k] = pat[k];
          if (which != 0) tb2[pos + k] = pat[k];
        end
        pos += $urandom_range(1, plen);
      end else begin
        pos++;
      end
    end
    for (int k = 0; k < n; k++) begin
      push_pair(ta[k], tb2[k], with_last && (k == n - 1));
    end
  endtask

  initial begin
    int r, eff;
    logic [6:0] len;
    clear_hash_state();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, zero and over-long windows
    write_reg(dsrhm_pkg::REG_PATTERN_HASH, 64'd0);
    push_pair(8'h00, 8'h00, 1'b0);
    push_pair(8'hFF, 8'h00, 1'b0);
    push_pair(8'h00, 8'hFF, 1'b0);
    push_pair(8'hFF, 8'hFF, 1'b0);
    push_pair(8'h00, 8'h00, 1'b1);
    wait_drained();
    write_reg(dsrhm_pkg::REG_PATTERN_LENGTH, 64'd0);
    write_reg(dsrhm_pkg::REG_PATTERN_HASH, 64'h41);
    push_pair(8'h41, 8'h41, 1'b0);
    push_pair(8'h41, 8'h00, 1'b0);
    push_pair(8'h00, 8'h41, 1'b0);
    push_pair(8'h41, 8'h41, 1'b1);
    wait_drained();
    write_reg(dsrhm_pkg::REG_PATTERN_LENGTH, 64'd127);
    write_reg(dsrhm_pkg::REG_PATTERN_HASH, 64'hFFFF_FFFF_FFFF_FFFF);
    push_pair(8'hFF, 8'hFF, 1'b0);
    push_pair(8'h00, 8'h00, 1'b0);
    push_pair(8'h41, 8'h41, 1'b1);
    wait_drained();

    // random phases; some streams run on across a length change
    while (items_sent < 1050) begin
      phases++;
      r = $urandom_range(0, 19);
      if (r == 0) len = 7'd0;
      else if (r == 1) len = 7'($urandom_range(65, 127));
      else if (r == 2) len = 7'd64;
      else if (r < 6) len = 7'($urandom_range(9, 63));
      else len = 7'($urandom_range(1, 8));
      load_pattern(len);
      eff = pat.size();
      idle_on = ($urandom_range(0, 3) != 0);
      calm = (items_sent > 900);
      if (phases == 3) begin
        hold_asked++;
        queue_text(eff + 120, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          queue_text($urandom_range(1, eff + 40), $urandom_range(0, 7) != 0);
        end
      end
      wait_drained();
    end

    $display("Covered %0d pairs in %0d phases: %0d results checked,", items_sent, phases,
             results_checked);
    $display("%0d common matches and %0d single-stream matches", common_hits, single_hits);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
